// ===== hw/rtl/pal_pkg.sv =====
// Shared widths, request codes and controller/datapath interface types.
package pal_pkg;

  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int REQ_W  = 2;

  localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;   // capture the incoming request
    logic decide;  // check the request, start the first read of a read or delete
    logic grab;    // capture the read data as the result value
    logic step;    // move one entry: read next, write previous
    logic drain;   // write the last entry read
    logic put;     // write the inserted value
    logic finish;  // load the output register, update the count
  } pal_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic legal;
    logic op_read;
    logic op_ins;
    logic op_del;
    logic append;     // insert lands just past the last entry
    logic del_last;   // delete removes the last entry
    logic last_read;  // current shift read is the final one
    logic out_free;   // output register can take a result
  } pal_sts_t;

endpackage

// ===== hw/rtl/positional_array_list.sv =====
// Read: decide, grab, finish; append: decide, put, finish; rejected: decide, finish.
// Insert shifts entries, drains, then puts the value; delete grabs, then shifts and
// drains unless it removes the last entry. One entry moves per cycle through the RAM.
// One request is handled at a time; the next is accepted in the cycle after the result loads.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
module positional_array_list
  import pal_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [REQ_W-1:0]             in_req_type,
  input  logic [POS_W-1:0]             in_position,
  input  logic signed [DATA_W-1:0]     in_write_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ok,
  output logic signed [DATA_W-1:0]     out_read_value,
  output logic [$clog2(DEPTH+1)-1:0]   out_count_after
);

  pal_cmd_t cmd;
  pal_sts_t sts;

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_read_value  (out_read_value),
    .out_count_after (out_count_after)
  );

endmodule

// ===== hw/rtl/pal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pal_ctrl.sv =====
// Controller state machine sequencing read, insert and delete requests.
module pal_ctrl
  import pal_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pal_sts_t sts,
  output pal_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_GRAB   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!sts.legal) begin
          state_nxt = S_FIN;
        end else if (sts.op_read || sts.op_del) begin
          state_nxt = S_GRAB;
        end else if (sts.append) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_GRAB: begin
        cmd.grab = 1'b1;
        if (sts.op_del && !sts.del_last) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SHIFT: begin
        cmd.step = 1'b1;
        if (sts.last_read) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = sts.op_ins ? S_PUT : S_FIN;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  a_accept_decides: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECIDE))
    else $error("accepted request did not enter the decide step");

  a_fin_released: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && sts.out_free) |=> (state_r == S_IDLE))
    else $error("finished request did not release the controller");

  a_state_known: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= S_FIN)
    else $error("controller state out of range");

endmodule

// ===== hw/rtl/pal_dp.sv =====
// Datapath: request registers, entry RAM, shift pointers, count and output register.
module pal_dp
  import pal_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pal_cmd_t                         cmd,
  output pal_sts_t                         sts,
  input  logic [REQ_W-1:0]                 in_req_type,
  input  logic [POS_W-1:0]                 in_position,
  input  logic signed [DATA_W-1:0]         in_write_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_ok,
  output logic signed [DATA_W-1:0]         out_read_value,
  output logic [$clog2(DEPTH+1)-1:0]       out_count_after
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int EXT_W = POS_W + 1;

  logic [REQ_W-1:0]         req_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] wval_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     ok_r;
  logic signed [DATA_W-1:0] result_r;
  logic [AW-1:0]            rd_ptr_r;
  logic [AW-1:0]            wr_addr_r;
  logic                     wr_pend_r;
  logic                     out_valid_r;
  logic                     out_ok_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [CNT_W-1:0]         out_count_r;

  logic [EXT_W-1:0]  pos_e, cnt_e;
  logic [POS_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  cnt_m1;
  logic [AW-1:0]     p0_a, cm1_a;
  logic              out_load;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign pos_e  = {1'b0, pos_r};
  assign cnt_e  = EXT_W'(count_r);
  assign pos_m1 = pos_r - POS_W'(1);
  assign cnt_m1 = count_r - CNT_W'(1);
  assign p0_a   = pos_m1[AW-1:0];
  assign cm1_a  = cnt_m1[AW-1:0];

  always_comb begin
    sts.op_read  = (req_r == REQ_READ);
    sts.op_ins   = (req_r == REQ_INSERT);
    sts.op_del   = (req_r == REQ_DELETE);
    sts.append   = (pos_e == cnt_e + EXT_W'(1));
    sts.del_last = (pos_e == cnt_e);
    sts.legal    = 1'b0;
    if (sts.op_read || sts.op_del) begin
      sts.legal = (pos_r != '0) && (pos_e <= cnt_e);
    end else if (sts.op_ins) begin
      sts.legal = (cnt_e < EXT_W'(DEPTH)) && (pos_r != '0) &&
                  (pos_e <= cnt_e + EXT_W'(1));
    end
    sts.last_read = sts.op_ins ? (rd_ptr_r == p0_a) : (rd_ptr_r == cm1_a);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // Entry RAM: moves read one entry ahead of the write
  assign ram_re    = (cmd.decide && sts.legal && (sts.op_read || sts.op_del)) || cmd.step;
  assign ram_raddr = cmd.decide ? p0_a : rd_ptr_r;
  assign ram_we    = cmd.put || ((cmd.step || cmd.drain) && wr_pend_r);
  assign ram_waddr = cmd.put ? p0_a : wr_addr_r;
  assign ram_wdata = cmd.put ? wval_r : ram_rdata;

  pal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req_type;
      pos_r  <= in_position;
      wval_r <= in_write_value;
    end
    if (cmd.decide) begin
      ok_r     <= sts.legal;
      rd_ptr_r <= sts.op_ins ? cm1_a : p0_a + AW'(1);
    end
    if (cmd.grab) begin
      result_r <= ram_rdata;
    end
    if (cmd.step) begin
      rd_ptr_r  <= sts.op_ins ? rd_ptr_r - AW'(1) : rd_ptr_r + AW'(1);
      wr_addr_r <= sts.op_ins ? rd_ptr_r + AW'(1) : rd_ptr_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else if (cmd.decide) begin
      wr_pend_r <= 1'b0;
    end else if (cmd.step) begin
      wr_pend_r <= 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ok_r && sts.op_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ok_r && sts.op_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign out_load = cmd.finish && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r    <= ok_r;
      out_value_r <= (ok_r && !sts.op_ins) ? result_r : '0;
      out_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_read_value  = out_value_r;
  assign out_count_after = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above list depth");

  a_move_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && wr_pend_r) |-> (wr_addr_r != rd_ptr_r))
    else $error("shift writes the entry it is reading");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_ok_r) &&
      $stable(out_value_r) && $stable(out_count_r)))
    else $error("stalled result changed");

endmodule

// ===== tb/positional_array_list_check.sv =====
// Checker for positional_array_list: tracks the list, predicts each reply, compares.
`timescale 1ns / 100ps
module positional_array_list_check
  import pal_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [REQ_W-1:0]             in_req_type,
  input  logic [POS_W-1:0]             in_position,
  input  logic signed [DATA_W-1:0]     in_write_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_ok,
  input  logic signed [DATA_W-1:0]     out_read_value,
  input  logic [$clog2(DEPTH+1)-1:0]   out_count_after,
  output int                           fail_count,
  output int                           outstanding
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic                      ok;
    logic signed [DATA_W-1:0]  value;
    logic [CNT_W-1:0]          count;
  } list_reply_t;

  logic signed [DATA_W-1:0] slots [DEPTH];
  int unsigned              held;
  list_reply_t              replies_due [$];
  int                       errors;

  initial begin
    held        = 0;
    errors      = 0;
    fail_count  = 0;
    outstanding = 0;
  end

  // Apply one request to the tracked list and return the reply it earns.
  function automatic list_reply_t apply_list_request(input logic [REQ_W-1:0] kind,
                                                     input int unsigned pos,
                                                     input logic signed [DATA_W-1:0] value);
    list_reply_t r;
    r.ok    = 1'b0;
    r.value = '0;
    case (kind)
      REQ_READ: begin
        if (pos >= 1 && pos <= held) begin
          r.ok    = 1'b1;
          r.value = slots[pos-1];
        end
      end
      REQ_INSERT: begin
        if (held < DEPTH && pos >= 1 && pos <= held + 1) begin
          for (int k = held; k >= pos; k--) slots[k] = slots[k-1];
          slots[pos-1] = value;
          held++;
          r.ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (pos >= 1 && pos <= held) begin
          r.value = slots[pos-1];
          for (int k = pos; k < held; k++) slots[k-1] = slots[k];
          held--;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(held);
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [DATA_W-1:0] want,
                            input logic [DATA_W-1:0] got);
    errors++;
    $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch_channels
    list_reply_t want;
    if (!rst_n) begin
      held = 0;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: reply with nothing pending: ok %0b value %0h count %0d",
                   $time, out_ok, out_read_value, out_count_after);
        end else begin
          want = replies_due.pop_front();
          if (out_ok !== want.ok)
            flag_field("ok", DATA_W'(want.ok), DATA_W'(out_ok));
          if (out_read_value !== want.value)
            flag_field("read_value", want.value, out_read_value);
          if (out_count_after !== want.count)
            flag_field("count_after", DATA_W'(want.count), DATA_W'(out_count_after));
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(apply_list_request(in_req_type, 32'(in_position),
                                                 in_write_value));
    end
    outstanding <= replies_due.size();
    fail_count  <= errors;
  end

endmodule

// ===== tb/tb_positional_array_list.sv =====
// Testbench top for positional_array_list: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps
module tb_positional_array_list
  import pal_pkg::*;
();

  localparam int DEPTH           = 16;
  localparam int CNT_W           = $clog2(DEPTH + 1);
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int PHASE_ITEMS     = 282;
  localparam int BURST_LEN       = 40;

  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  typedef enum int {MIXED_BURST, FILL_BURST, DRAIN_BURST} burst_t;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic [REQ_W-1:0]            in_req_type    = '0;
  logic [POS_W-1:0]            in_position    = '0;
  logic signed [DATA_W-1:0]    in_write_value = '0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic                        out_ok;
  logic signed [DATA_W-1:0]    out_read_value;
  logic [CNT_W-1:0]            out_count_after;

  logic hold_rx      = 1'b0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  int   list_len     = 0;
  int   idle_cycles  = 0;
  int   fail_count;
  int   outstanding;

  positional_array_list #(.DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_read_value  (out_read_value),
    .out_count_after (out_count_after)
  );

  positional_array_list_check #(.DEPTH(DEPTH)) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_read_value  (out_read_value),
    .out_count_after (out_count_after),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        hold_rx   <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("positional_array_list: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, hold it until accepted, then maybe go idle.
  task automatic send_request(input logic [REQ_W-1:0] kind, input int unsigned pos,
                              input logic signed [DATA_W-1:0] value);
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_position    <= POS_W'(pos);
    in_write_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Track the length only to steer positions toward the live range.
    case (kind)
      REQ_INSERT: begin
        if (list_len < DEPTH && pos >= 1 && pos <= list_len + 1) list_len++;
      end
      REQ_DELETE: begin
        if (pos >= 1 && pos <= list_len) list_len--;
      end
      default: ;
    endcase
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request(input burst_t bias);
    logic [REQ_W-1:0] kind;
    int unsigned      roll;
    int unsigned      pos;
    int unsigned      top_pos;
    roll = $urandom_range(99);
    case (bias)
      FILL_BURST:  kind = (roll < 80) ? REQ_INSERT : (roll < 92) ? REQ_READ : REQ_DELETE;
      DRAIN_BURST: kind = (roll < 80) ? REQ_DELETE : (roll < 92) ? REQ_READ : REQ_INSERT;
      default:     kind = (roll < 35) ? REQ_READ : (roll < 67) ? REQ_INSERT : REQ_DELETE;
    endcase
    if ($urandom_range(99) < 3) kind = REQ_SPARE;
    top_pos = (kind == REQ_INSERT) ? list_len + 1 : list_len;
    roll    = $urandom_range(99);
    if (roll < 10)
      pos = $urandom_range(63);
    else if (roll < 16)
      pos = top_pos;
    else
      pos = $urandom_range(1, (top_pos > 0) ? top_pos : 1);
    send_request(kind, pos, pick_value());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list, bad positions, front/middle/append, extremes, unused type.
    send_request(REQ_READ,   1,  0);
    send_request(REQ_DELETE, 1,  0);
    send_request(REQ_INSERT, 0,  32'sh1234_5678);
    send_request(REQ_INSERT, 2,  32'sh1234_5678);
    send_request(REQ_INSERT, 1,  32'sh8000_0000);
    send_request(REQ_INSERT, 2,  32'sh7FFF_FFFF);
    send_request(REQ_INSERT, 1,  -32'sd1);
    send_request(REQ_INSERT, 2,  32'sd0);
    send_request(REQ_READ,   1,  0);
    send_request(REQ_READ,   4,  0);
    send_request(REQ_READ,   5,  0);
    send_request(REQ_READ,   0,  0);
    send_request(REQ_READ,   63, 0);
    send_request(REQ_SPARE,  1,  32'sh5A5A_5A5A);
    send_request(REQ_DELETE, 0,  0);
    send_request(REQ_DELETE, 5,  0);
    send_request(REQ_DELETE, 2,  0);
    send_request(REQ_DELETE, 3,  0);
    send_request(REQ_INSERT, 63, -32'sd1);
    send_request(REQ_INSERT, 4,  32'sd7);
    wait_all_replies();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 100) begin
          // Back up the block behind a long receiver hold-off, then drain.
          hold_rx <= 1'b1;
          repeat (30) random_request(MIXED_BURST);
          wait_all_replies();
        end
        random_request(burst_t'((n / BURST_LEN) % 3));
      end
      wait_all_replies();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("positional_array_list: match");
    else
      $display("positional_array_list: mismatch");
    $finish;
  end

endmodule
